[src/spq_pkg.sv]
// Shared constants, codes and control structures of the stable priority queue.
package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_WIDTH = 16;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int POS_W     = 5;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                 ins;
      logic                 rem;
      logic [1:0]           prio;
      logic [TAG_WIDTH-1:0] payload;
      logic [IDX_W-1:0]     rem_idx;
      logic [CNT_W-1:0]     count;
   } cell_cmd_type;

   // Result description handed from the control to the response register.
   typedef struct packed {
      status_type       status;
      logic             take;
      logic [CNT_W-1:0] occupancy;
   } ctrl_rsp_type;

endpackage

[src/spq_ifs.sv]
// Request and response channel interfaces of the stable priority queue.
interface spq_req_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           op;
   logic [1:0]           prio;
   logic [TAG_WIDTH-1:0] payload;
   logic [POS_W-1:0]     position;

   modport source (output valid, output op, output prio, output payload,
                   output position, input ready);
   modport sink   (input valid, input op, input prio, input payload,
                   input position, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [TAG_WIDTH-1:0] out_payload;
   logic [1:0]           out_prio;
   logic [CNT_W-1:0]     occupancy;

   modport source (output valid, output status, output out_payload,
                   output out_prio, output occupancy, input ready);
   modport sink   (input valid, input status, input out_payload,
                   input out_prio, input occupancy, output ready);
endinterface

[src/spq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
module spq_cell import spq_pkg::*; (
   input  logic                 clock,
   input  logic                 fire,
   input  cell_cmd_type         cmd,
   input  logic [IDX_W-1:0]     cell_idx,
   input  logic                 left_ge,
   input  logic [1:0]           left_prio,
   input  logic [TAG_WIDTH-1:0] left_payload,
   input  logic [1:0]           right_prio,
   input  logic [TAG_WIDTH-1:0] right_payload,
   output logic                 ge,
   output logic [1:0]           prio,
   output logic [TAG_WIDTH-1:0] payload
);

   logic [1:0]           prio_ff, prio_in;
   logic [TAG_WIDTH-1:0] payload_ff, payload_in;
   logic                 occupied;

   // The chain is sorted, so the cells that outrank the new entry form a prefix.
   assign occupied = {{(CNT_W - IDX_W){1'b0}}, cell_idx} < cmd.count;
   assign ge       = occupied && (prio_ff >= cmd.prio);

   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (cmd.ins && !ge) begin
         if (left_ge) begin
            prio_in    = cmd.prio;
            payload_in = cmd.payload;
         end else begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end else if (cmd.rem && (cell_idx >= cmd.rem_idx)) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prio_ff    <= prio_in;
         payload_ff <= payload_in;
      end
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

[src/spq_ctrl.sv]
// Operation decode, status selection and entry count of the stable priority queue.
module spq_ctrl import spq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           op,
   input  logic [1:0]           prio,
   input  logic [TAG_WIDTH-1:0] payload,
   input  logic [POS_W-1:0]     position,
   output cell_cmd_type         cmd,
   output ctrl_rsp_type         rsp
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0] pos_wide, count_wide;
   logic [POS_W-1:0] pos_m1;
   logic             pos_ok;

   assign pos_wide   = CMP_W'(position);
   assign count_wide = CMP_W'(count_ff);
   assign pos_m1     = position - POS_W'(1);
   assign pos_ok     = (position != '0) && (pos_wide <= count_wide);

   always_comb begin
      cmd.ins     = 1'b0;
      cmd.rem     = 1'b0;
      cmd.prio    = prio;
      cmd.payload = payload;
      cmd.rem_idx = '0;
      cmd.count   = count_ff;
      rsp.status  = ST_OK;
      rsp.take    = 1'b0;
      count_in    = count_ff;
      case (op_type'(op))
         OP_INSERT: begin
            if (count_ff >= CNT_W'(DEPTH)) begin
               rsp.status = ST_FULL;
            end else begin
               cmd.ins  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               rsp.status = ST_EMPTY;
            end else begin
               cmd.rem  = 1'b1;
               rsp.take = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            cmd.rem_idx = IDX_W'(pos_m1);
            if (count_ff == '0) begin
               rsp.status = ST_EMPTY;
            end else if (!pos_ok) begin
               rsp.status = ST_BADPOS;
            end else begin
               cmd.rem  = 1'b1;
               rsp.take = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp.status = ST_OK;
         end
      endcase
      rsp.occupancy = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

endmodule

[src/stable_priority_queue.sv]
// Top level of the stable priority queue: control, chain of cells and response register.
// The response word appears in the cycle after the request word is accepted.
// One operation per cycle while rsp_ch drains; all cells compare and shift in parallel.
// A request is taken whenever the response register is empty or is being drained.
// Reset clears the entry count and the response valid; slot contents are not cleared,
// since a slot is read only after it has been written.
module stable_priority_queue import spq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   cell_cmd_type cmd;
   ctrl_rsp_type crsp;
   logic         fire;

   logic                 cell_ge      [DEPTH];
   logic [1:0]           cell_prio    [DEPTH];
   logic [TAG_WIDTH-1:0] cell_payload [DEPTH];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [TAG_WIDTH-1:0] rsp_payload_ff, rsp_payload_in;
   logic [1:0]           rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]     rsp_occ_ff;

   // The response register frees up in the same cycle that its word is taken,
   // so back-to-back operations flow while the consumer keeps up.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;

   spq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .op       (req_ch.op),
      .prio     (req_ch.prio),
      .payload  (req_ch.payload),
      .position (req_ch.position),
      .cmd      (cmd),
      .rsp      (crsp)
   );

   // Each cell sees the outrank flag and contents of its left neighbor for an
   // insert, and the contents of its right neighbor for a removal. The head cell
   // treats its missing left neighbor as outranking, so a new top entry lands
   // there; the tail cell pulls in don't-care data that lies beyond the count.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 l_ge;
      logic [1:0]           l_prio, r_prio;
      logic [TAG_WIDTH-1:0] l_payload, r_payload;

      if (i == 0) begin : g_head
         assign l_ge      = 1'b1;
         assign l_prio    = '0;
         assign l_payload = '0;
      end else begin : g_body
         assign l_ge      = cell_ge[i-1];
         assign l_prio    = cell_prio[i-1];
         assign l_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_prio    = '0;
         assign r_payload = '0;
      end else begin : g_next
         assign r_prio    = cell_prio[i+1];
         assign r_payload = cell_payload[i+1];
      end

      spq_cell u_cell (
         .clock         (clock),
         .fire          (fire),
         .cmd           (cmd),
         .cell_idx      (IDX_W'(i)),
         .left_ge       (l_ge),
         .left_prio     (l_prio),
         .left_payload  (l_payload),
         .right_prio    (r_prio),
         .right_payload (r_payload),
         .ge            (cell_ge[i]),
         .prio          (cell_prio[i]),
         .payload       (cell_payload[i])
      );
   end

   // The removed entry is read out of its cell before the chain closes the gap.
   always_comb begin
      rsp_payload_in = '0;
      rsp_prio_in    = '0;
      if (crsp.take) begin
         rsp_payload_in = cell_payload[cmd.rem_idx];
         rsp_prio_in    = cell_prio[cmd.rem_idx];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff  <= crsp.status;
         rsp_payload_ff <= rsp_payload_in;
         rsp_prio_ff    <= rsp_prio_in;
         rsp_occ_ff     <= crsp.occupancy;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.out_payload = rsp_payload_ff;
   assign rsp_ch.out_prio    = rsp_prio_ff;
   assign rsp_ch.occupancy   = rsp_occ_ff;

endmodule

[tb/sv/stable_priority_queue_test.sv]
// Self-checking testbench for the stable priority queue: random and directed operations.
module stable_priority_queue_test;
   import spq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A run stops if this many cycles pass with no word moving on either channel.
   localparam int STALL_LIMIT   = 3000;
   // The response word appears in the cycle after its request is taken; the spare cycles at the end
   // catch any stray response that the block might still produce.
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_WORDS  = 1200;
   // The idling pattern changes every time this many request words have been taken.
   localparam int PHASE_WORDS   = 100;

   // One request word, as the driver puts it on the request channel.
   typedef struct packed {
      op_type               op;
      logic [1:0]           prio;
      logic [TAG_WIDTH-1:0] payload;
      logic [POS_W-1:0]     position;
   } queue_cmd;

   // One response word, as the queue is expected to return it.
   typedef struct packed {
      status_type           status;
      logic [TAG_WIDTH-1:0] out_payload;
      logic [1:0]           out_prio;
      logic [CNT_W-1:0]     occupancy;
   } queue_result;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Request words still to be sent, and responses predicted but not yet seen.
   queue_cmd    pending_cmds[$];
   queue_result expected_results[$];

   // Shadow copy of the queue contents, kept in descending priority order.
   logic [1:0]           held_prio[DEPTH];
   logic [TAG_WIDTH-1:0] held_tag[DEPTH];
   int                   held_count = 0;

   // Occupancy the generator expects at the point where a new word is appended;
   // it lets the random part aim removal positions at live entries.
   int gen_count = 0;

   int   mismatch_count = 0;
   int   taken_words    = 0;
   int   quiet_cycles   = 0;
   logic req_fired      = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, seen, wanted);
      mismatch_count++;
   endtask

   // Applies one operation to the shadow queue and returns the response it must give.
   function automatic queue_result apply_cmd(input queue_cmd c);
      queue_result r;
      int          slot;
      int          take;
      r.status      = ST_OK;
      r.out_payload = '0;
      r.out_prio    = '0;
      take          = -1;
      case (c.op)
         OP_INSERT: begin
            if (held_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // The new entry goes behind every entry of equal or higher priority,
               // which keeps entries of one priority in arrival order.
               slot = 0;
               while (slot < held_count && held_prio[slot] >= c.prio) slot++;
               for (int i = held_count; i > slot; i--) begin
                  held_prio[i] = held_prio[i - 1];
                  held_tag[i]  = held_tag[i - 1];
               end
               held_prio[slot] = c.prio;
               held_tag[slot]  = c.payload;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count == 0) r.status = ST_EMPTY;
            else take = 0;
         end
         OP_REMOVE: begin
            if (held_count == 0) r.status = ST_EMPTY;
            else if (c.position == 0 || c.position > held_count) r.status = ST_BADPOS;
            else take = c.position - 1;
         end
         default: ;
      endcase
      if (take >= 0) begin
         r.out_payload = held_tag[take];
         r.out_prio    = held_prio[take];
         for (int i = take; i + 1 < held_count; i++) begin
            held_prio[i] = held_prio[i + 1];
            held_tag[i]  = held_tag[i + 1];
         end
         held_count--;
      end
      r.occupancy = CNT_W'(held_count);
      return r;
   endfunction

   // Appends one request word and tracks the occupancy it will leave behind.
   task automatic queue_word(input op_type op, input int prio, input int payload,
                             input int position);
      queue_cmd c;
      c.op       = op;
      c.prio     = 2'(prio);
      c.payload  = TAG_WIDTH'(payload);
      c.position = POS_W'(position);
      pending_cmds.push_back(c);
      case (op)
         OP_INSERT: if (gen_count < DEPTH) gen_count++;
         OP_POP:    if (gen_count > 0) gen_count--;
         OP_REMOVE: if (position >= 1 && position <= gen_count) gen_count--;
         default: ;
      endcase
   endtask

   // Idling pattern of the current phase: none, sender idle, receiver stalling, both.
   function automatic int idle_phase();
      return (taken_words / PHASE_WORDS) % 4;
   endfunction

   // Driver. A word stays on the channel until it is taken; a new one is chosen only
   // when the channel is empty or the previous word moved at the last rising edge.
   always @(negedge clock) begin
      queue_cmd c;
      int       phase;
      logic     hold_off;
      phase = idle_phase();
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || req_fired) begin
            hold_off = (phase == 1) ? ($urandom_range(99) < 79) :
                       (phase == 3) ? ($urandom_range(99) < 19) : 1'b0;
            if (pending_cmds.size() > 0 && !hold_off) begin
               c = pending_cmds.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.op       <= c.op;
               req_ch.prio     <= c.prio;
               req_ch.payload  <= c.payload;
               req_ch.position <= c.position;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= (phase == 2) ? ($urandom_range(99) >= 79) :
                         (phase == 3) ? ($urandom_range(99) >= 19) : 1'b1;
      end
   end

   // Monitor and checker. The response side is checked before the request side is
   // predicted, so a response and a new request in the same cycle never get mixed up.
   always @(posedge clock) begin
      queue_cmd    c;
      queue_result want;
      logic        moved;
      moved = 1'b0;
      req_fired <= req_ch.valid && req_ch.ready && !reset;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
               report_mismatch("response word with nothing expected",
                               32'(rsp_ch.status), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
               if (rsp_ch.out_payload !== want.out_payload)
                  report_mismatch("out_payload", 32'(rsp_ch.out_payload),
                                  32'(want.out_payload));
               if (rsp_ch.out_prio !== want.out_prio)
                  report_mismatch("out_prio", 32'(rsp_ch.out_prio), 32'(want.out_prio));
               if (rsp_ch.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_ch.occupancy),
                                  32'(want.occupancy));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved      = 1'b1;
            c.op       = op_type'(req_ch.op);
            c.prio     = req_ch.prio;
            c.payload  = req_ch.payload;
            c.position = req_ch.position;
            expected_results.push_back(apply_cmd(c));
            taken_words++;
         end
      end
      // Watchdog: a hung handshake ends the run as a failure.
      if (moved) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int mode;
      int roll;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_NONE;
      req_ch.prio     = '0;
      req_ch.payload  = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;

      // Directed part: both empty cases, the unused selector, a fill past full with
      // mixed and equal priorities and extreme tags, then bad and good positions.
      queue_word(OP_POP, 3, 16'hFFFF, 31);
      queue_word(OP_REMOVE, 3, 16'hFFFF, 1);
      queue_word(OP_NONE, 3, 16'hFFFF, 31);
      for (int i = 0; i < DEPTH + 1; i++)
         queue_word(OP_INSERT, i % 4, (i % 2) ? 16'hFFFF - i : i, 31 - i);
      queue_word(OP_REMOVE, 0, 0, 0);
      queue_word(OP_REMOVE, 0, 0, DEPTH + 1);
      queue_word(OP_REMOVE, 0, 0, DEPTH);
      queue_word(OP_REMOVE, 0, 0, 1);
      queue_word(OP_POP, 0, 0, 0);

      // Random part in stretches that lean toward filling, draining or neither,
      // so the occupancy sweeps between empty and full many times.
      mode = 2;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) mode = $urandom_range(2);
         roll = $urandom_range(99);
         if (roll < ((mode == 0) ? 70 : (mode == 1) ? 25 : 50)) begin
            queue_word(OP_INSERT, $urandom_range(3), $urandom_range(16'hFFFF),
                       $urandom_range(31));
         end else begin
            roll = $urandom_range(99);
            if (roll < 5)
               queue_word(OP_NONE, $urandom_range(3), $urandom_range(16'hFFFF),
                          $urandom_range(31));
            else if (roll < 45)
               queue_word(OP_POP, $urandom_range(3), $urandom_range(16'hFFFF),
                          $urandom_range(31));
            else if ($urandom_range(99) < 85)
               queue_word(OP_REMOVE, $urandom_range(3), $urandom_range(16'hFFFF),
                          $urandom_range((gen_count > 0) ? gen_count : 1, 1));
            else
               queue_word(OP_REMOVE, $urandom_range(3), $urandom_range(16'hFFFF),
                          $urandom_range(31));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every response to be checked.
      @(negedge clock);
      while (pending_cmds.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0)
         report_mismatch("responses still expected", 32'd0, expected_results.size());
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
